/* design/spa_pkg.sv */
// Shared types and constants for the sparse polynomial adder.
// Used by spa_table, sparse_polynomial_adder and the testbench; depends on nothing else.
package spa_pkg;

  localparam int TERMS  = 32;
  localparam int ADDR_W = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int CNT_W  = $clog2(TERMS + 1);

  localparam logic [1:0] FUNC_INS_A = 2'd0;
  localparam logic [1:0] FUNC_INS_B = 2'd1;
  localparam logic [1:0] FUNC_SUM   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_COMBINED  = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_ZERO      = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_SUM       = 3'd5;
  localparam logic [2:0] ST_SUM_EMPTY = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef struct packed {
    logic signed [15:0] pw;
    logic signed [31:0] cf;
  } spa_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    spa_entry_t        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              cnt_clr;
  } spa_tbl_ctl_t;

endpackage

/* design/spa_table.sv */
// One term table: entry memory with a registered read port and the term count.
// Depends on spa_pkg.
module spa_table
  import spa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  spa_tbl_ctl_t     ctl,
  output spa_entry_t       rd_data,
  output logic [CNT_W-1:0] count
);

  spa_entry_t       mem [TERMS];
  spa_entry_t       rd_data_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data_r <= mem[ctl.rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_clr) begin
      count_nxt = '0;
    end else if (ctl.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

/* design/sparse_polynomial_adder.sv */
// Top level of the sparse polynomial adder: sequencer, shared add/compare unit, output register.
// Depends on spa_pkg and spa_table.
//
// The block keeps two sparse polynomials A and B, each a table of up to TERMS terms sorted by
// strictly descending power with nonzero coefficients only. A transaction on the input channel
// carries a function code: insert into A, insert into B, emit the sum A+B, or clear both.
// Inserts and clear return one result transaction with last set; a sum returns one transaction
// per nonzero sum term in descending power (last on the final one), or one "sum empty"
// transaction. Coefficients add with 32-bit wraparound. The block works on one transaction at a
// time and holds in_stall high until it has finished its work; the result channel has its own
// output register, so a result waiting on out_stall does not hold off the next input.
// Each table is a single-port-read memory with a registered read, and every step of the
// sequencer is a read followed by a compare/add in the one shared unit or, when shifting, a write.
// An insert scans the entries above the insertion point and then shifts the entries below it up
// or down one place. A sum takes up to 2*TERMS merge steps plus the emission of each term, longer
// if out_stall holds the output. Clear resets both term counts and emits its result directly.
// No clearing pass is needed after reset: only entries below each table's count are ever used.
module sparse_polynomial_adder
  import spa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_term_coeff,
  input  logic signed [15:0] in_term_power,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_coeff,
  output logic signed [15:0] out_power,
  output logic               out_last
);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_SHU     = 4'd3;
  localparam logic [3:0] S_SHU_WR  = 4'd4;
  localparam logic [3:0] S_SHD     = 4'd5;
  localparam logic [3:0] S_SHD_WR  = 4'd6;
  localparam logic [3:0] S_SUM_RD  = 4'd7;
  localparam logic [3:0] S_SUM_CHK = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [3:0]         ret_r, ret_nxt;
  logic               tsel_r, tsel_nxt;
  logic signed [31:0] coeff_r, coeff_nxt;
  logic signed [15:0] power_r, power_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   jdx_r, jdx_nxt;
  logic [CNT_W-1:0]   ia_r, ia_nxt;
  logic [CNT_W-1:0]   ib_r, ib_nxt;
  logic               pend_r, pend_nxt;
  spa_entry_t         pend_ent_r, pend_ent_nxt;
  logic [2:0]         res_st_r, res_st_nxt;
  spa_entry_t         res_ent_r, res_ent_nxt;
  logic               res_last_r, res_last_nxt;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  spa_entry_t         out_ent_r;
  logic               out_last_r;
  logic               slot_free;

  spa_tbl_ctl_t       ctl_a, ctl_b, tctl;
  spa_entry_t         a_rd, b_rd, t_rd;
  logic [CNT_W-1:0]   a_cnt, b_cnt, t_cnt;

  // Shared arithmetic unit: one power comparator and one coefficient adder
  logic signed [15:0] cmp_x, cmp_y;
  logic signed [31:0] add_x, add_y, add_s;
  logic               cmp_gt, cmp_eq;

  logic               a_live, b_live;
  spa_entry_t         pick;
  logic               take_a, take_b;

  spa_table u_tab_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .rd_data (a_rd),
    .count   (a_cnt)
  );

  spa_table u_tab_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .rd_data (b_rd),
    .count   (b_cnt)
  );

  assign t_rd  = tsel_r ? b_rd : a_rd;
  assign t_cnt = tsel_r ? b_cnt : a_cnt;

  always_comb begin
    if (state_r == S_SUM_CHK) begin
      cmp_x = a_rd.pw;
      cmp_y = b_rd.pw;
      add_x = a_rd.cf;
      add_y = b_rd.cf;
    end else begin
      cmp_x = t_rd.pw;
      cmp_y = power_r;
      add_x = t_rd.cf;
      add_y = coeff_r;
    end
  end

  assign cmp_gt = cmp_x > cmp_y;
  assign cmp_eq = cmp_x == cmp_y;
  assign add_s  = add_x + add_y;

  // Merge step selection for the sum walk
  assign a_live = ia_r < a_cnt;
  assign b_live = ib_r < b_cnt;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    pick   = a_rd;
    if (!b_live || (a_live && cmp_gt)) begin
      take_a = 1'b1;
      pick   = a_rd;
    end else if (!a_live || !cmp_eq) begin
      take_b = 1'b1;
      pick   = b_rd;
    end else begin
      take_a  = 1'b1;
      take_b  = 1'b1;
      pick.pw = a_rd.pw;
      pick.cf = add_s;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    tsel_nxt     = tsel_r;
    coeff_nxt    = coeff_r;
    power_nxt    = power_r;
    idx_nxt      = idx_r;
    jdx_nxt      = jdx_r;
    ia_nxt       = ia_r;
    ib_nxt       = ib_r;
    pend_nxt     = pend_r;
    pend_ent_nxt = pend_ent_r;
    res_st_nxt   = res_st_r;
    res_ent_nxt  = res_ent_r;
    res_last_nxt = res_last_r;
    tctl         = '0;
    ctl_a        = '0;
    ctl_b        = '0;

    unique case (state_r)
      S_IDLE: begin
        res_ent_nxt  = '0;
        res_last_nxt = 1'b1;
        ret_nxt      = S_IDLE;
        if (in_valid) begin
          tsel_nxt  = in_func == FUNC_INS_B;
          coeff_nxt = in_term_coeff;
          power_nxt = in_term_power;
          idx_nxt   = '0;
          ia_nxt    = '0;
          ib_nxt    = '0;
          pend_nxt  = 1'b0;
          unique case (in_func)
            FUNC_INS_A, FUNC_INS_B: begin
              if (in_term_coeff == '0) begin
                res_st_nxt = ST_ZERO;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            FUNC_SUM: begin
              state_nxt = S_SUM_RD;
            end
            FUNC_CLEAR: begin
              ctl_a.cnt_clr = 1'b1;
              ctl_b.cnt_clr = 1'b1;
              res_st_nxt    = ST_CLEARED;
              state_nxt     = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Scan down the table for the first power not above the new one
      S_INS_RD: begin
        if (idx_r >= t_cnt) begin
          if (t_cnt >= CNT_W'(TERMS)) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_EMIT;
          end else begin
            jdx_nxt   = t_cnt;
            state_nxt = S_SHU;
          end
        end else begin
          tctl.rd_addr = idx_r[ADDR_W-1:0];
          state_nxt    = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        if (cmp_gt) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_INS_RD;
        end else if (cmp_eq) begin
          if (add_s != '0) begin
            tctl.wr_en      = 1'b1;
            tctl.wr_addr    = idx_r[ADDR_W-1:0];
            tctl.wr_data.pw = power_r;
            tctl.wr_data.cf = add_s;
            res_st_nxt      = ST_COMBINED;
            state_nxt       = S_EMIT;
          end else begin
            jdx_nxt   = idx_r;
            state_nxt = S_SHD;
          end
        end else if (t_cnt >= CNT_W'(TERMS)) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_EMIT;
        end else begin
          jdx_nxt   = t_cnt;
          state_nxt = S_SHU;
        end
      end

      // Open a slot at idx by moving entries up one place, top first
      S_SHU: begin
        if (jdx_r == idx_r) begin
          tctl.wr_en      = 1'b1;
          tctl.wr_addr    = idx_r[ADDR_W-1:0];
          tctl.wr_data.pw = power_r;
          tctl.wr_data.cf = coeff_r;
          tctl.cnt_inc    = 1'b1;
          res_st_nxt      = ST_NEW;
          state_nxt       = S_EMIT;
        end else begin
          tctl.rd_addr = ADDR_W'(jdx_r - CNT_W'(1));
          state_nxt    = S_SHU_WR;
        end
      end

      S_SHU_WR: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = jdx_r[ADDR_W-1:0];
        tctl.wr_data = t_rd;
        jdx_nxt      = jdx_r - CNT_W'(1);
        state_nxt    = S_SHU;
      end

      // Close the gap of a cancelled entry by moving the tail down one place
      S_SHD: begin
        if (jdx_r + CNT_W'(1) >= t_cnt) begin
          tctl.cnt_dec = 1'b1;
          res_st_nxt   = ST_CANCELLED;
          state_nxt    = S_EMIT;
        end else begin
          tctl.rd_addr = ADDR_W'(jdx_r + CNT_W'(1));
          state_nxt    = S_SHD_WR;
        end
      end

      S_SHD_WR: begin
        tctl.wr_en   = 1'b1;
        tctl.wr_addr = jdx_r[ADDR_W-1:0];
        tctl.wr_data = t_rd;
        jdx_nxt      = jdx_r + CNT_W'(1);
        state_nxt    = S_SHD;
      end

      // Sum walk: read the heads of both tables
      S_SUM_RD: begin
        if (!a_live && !b_live) begin
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          state_nxt    = S_EMIT;
          if (pend_r) begin
            res_st_nxt  = ST_SUM;
            res_ent_nxt = pend_ent_r;
          end else begin
            res_st_nxt  = ST_SUM_EMPTY;
            res_ent_nxt = '0;
          end
        end else begin
          ctl_a.rd_addr = ia_r[ADDR_W-1:0];
          ctl_b.rd_addr = ib_r[ADDR_W-1:0];
          state_nxt     = S_SUM_CHK;
        end
      end

      // Merge one step; hold the newest nonzero term back so last can be flagged
      S_SUM_CHK: begin
        if (take_a) begin
          ia_nxt = ia_r + CNT_W'(1);
        end
        if (take_b) begin
          ib_nxt = ib_r + CNT_W'(1);
        end
        state_nxt = S_SUM_RD;
        if (pick.cf != '0) begin
          pend_nxt     = 1'b1;
          pend_ent_nxt = pick;
          if (pend_r) begin
            res_st_nxt   = ST_SUM;
            res_ent_nxt  = pend_ent_r;
            res_last_nxt = 1'b0;
            ret_nxt      = S_SUM_RD;
            state_nxt    = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          state_nxt = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Route the single-table control to the table under insert
    if (state_r != S_IDLE && state_r != S_SUM_RD && state_r != S_SUM_CHK) begin
      if (tsel_r) begin
        ctl_b = tctl;
      end else begin
        ctl_a = tctl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tsel_r     <= tsel_nxt;
    coeff_r    <= coeff_nxt;
    power_r    <= power_nxt;
    idx_r      <= idx_nxt;
    jdx_r      <= jdx_nxt;
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    pend_ent_r <= pend_ent_nxt;
    res_st_r   <= res_st_nxt;
    res_ent_r  <= res_ent_nxt;
    res_last_r <= res_last_nxt;
  end

  // Output register: load a staged result when the slot is free, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && slot_free) begin
      out_status_r <= res_st_r;
      out_ent_r    <= res_ent_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_coeff  = out_ent_r.cf;
  assign out_power  = out_ent_r.pw;
  assign out_last   = out_last_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sparse_polynomial_adder: directed table, then random episodes.
// Depends on spa_pkg and the sparse_polynomial_adder RTL; predicts every result internally.
module testbench;
  import spa_pkg::*;

  localparam int RANDOM_ITEMS = 420;   // stop adding random episodes past this many commands after the directed rows
  localparam int QUIET_ITEMS  = 40;    // final stretch runs without any idling
  localparam int HOLD_AT      = 150;   // receiver freezes after this many input transactions
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;   // worst sum walk plus emission, with margin
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 40;

  // One command on the input channel. Rows with has_exp carry a hand-typed status.
  typedef struct {
    logic [1:0]  func;
    logic [31:0] coeff;
    logic [15:0] power;
    bit          has_exp;
    logic [2:0]  status;
  } command_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] coeff;
    logic signed [15:0] power;
    logic               last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FUNC_INS_A;
  logic signed [31:0] in_term_coeff = '0;
  logic signed [15:0] in_term_power = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_coeff;
  logic signed [15:0] out_power;
  logic               out_last;

  sparse_polynomial_adder DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_term_coeff (in_term_coeff),
    .in_term_power (in_term_power),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_coeff     (out_coeff),
    .out_power     (out_power),
    .out_last      (out_last)
  );

  always #4 clk = ~clk;

  // Directed part: extremes of power and coefficient, every command, zero coefficients,
  // merge, cancel, wrap to zero, wrap to nonzero, empty sum and a sum that cancels out.
  command_t directed_rows [23] = '{
    '{FUNC_SUM,   32'h00000000, 16'h0000, 1'b1, ST_SUM_EMPTY},  // nothing stored yet
    '{FUNC_INS_A, 32'h00000000, 16'h0005, 1'b1, ST_ZERO},
    '{FUNC_INS_B, 32'h00000000, 16'h8000, 1'b1, ST_ZERO},
    '{FUNC_INS_A, 32'h7fffffff, 16'h7fff, 1'b1, ST_NEW},
    '{FUNC_INS_A, 32'h80000000, 16'h8000, 1'b1, ST_NEW},
    '{FUNC_INS_A, 32'h00000001, 16'h0000, 1'b1, ST_NEW},        // lands between the extremes
    '{FUNC_INS_A, 32'h00000001, 16'h0000, 1'b1, ST_COMBINED},
    '{FUNC_INS_A, 32'hfffffffe, 16'h0000, 1'b1, ST_CANCELLED},
    '{FUNC_INS_B, 32'h00000001, 16'h7fff, 1'b1, ST_NEW},
    '{FUNC_INS_B, 32'h80000000, 16'h8000, 1'b1, ST_NEW},
    '{FUNC_INS_B, 32'hffffffff, 16'h0064, 1'b1, ST_NEW},
    '{FUNC_INS_B, 32'h00000005, 16'hffff, 1'b1, ST_NEW},
    '{FUNC_SUM,   32'hdeadbeef, 16'h8001, 1'b0, ST_SUM},        // top wraps, bottom cancels
    '{FUNC_INS_A, 32'h80000001, 16'h7fff, 1'b1, ST_CANCELLED},  // wraps to exactly zero
    '{FUNC_INS_A, 32'h7fffffff, 16'h0064, 1'b1, ST_NEW},
    '{FUNC_INS_A, 32'h7fffffff, 16'h0064, 1'b1, ST_COMBINED},   // wraps but stays nonzero
    '{FUNC_SUM,   32'h00000000, 16'h0000, 1'b0, ST_SUM},
    '{FUNC_CLEAR, 32'h00000000, 16'h0000, 1'b1, ST_CLEARED},
    '{FUNC_SUM,   32'h00000000, 16'h0000, 1'b1, ST_SUM_EMPTY},
    '{FUNC_INS_A, 32'h00000003, 16'h0009, 1'b1, ST_NEW},
    '{FUNC_INS_B, 32'hfffffffd, 16'h0009, 1'b1, ST_NEW},
    '{FUNC_SUM,   32'h00000000, 16'h0000, 1'b1, ST_SUM_EMPTY},  // A and B cancel term for term
    '{FUNC_CLEAR, 32'hffffffff, 16'hffff, 1'b1, ST_CLEARED}
  };

  command_t stimulus[$];
  result_t  owed_results[$];     // results the block still has to deliver, oldest first

  // Shadow copy of the two term tables; index 0 is A, index 1 is B.
  logic signed [15:0] poly_pw [2][TERMS];
  logic [31:0]        poly_cf [2][TERMS];
  int                 poly_len [2];

  int send_idx = 0;
  int errors = 0;
  int results_seen = 0;
  int cycle_cnt = 0;
  int status_hits [8];

  // ---------------------------------------------------------------------------------------
  // Term tables: insert, merge of both tables into a sum, clear.
  // ---------------------------------------------------------------------------------------
  function automatic logic [2:0] insert_term(int sel, logic [31:0] cf, logic signed [15:0] pw);
    int          i;
    logic [31:0] merged;
    i = 0;
    if (cf == 32'h0) return ST_ZERO;
    while (i < poly_len[sel] && poly_pw[sel][i] > pw) i++;
    if (i < poly_len[sel] && poly_pw[sel][i] == pw) begin
      merged = poly_cf[sel][i] + cf;
      poly_cf[sel][i] = merged;
      if (merged != 32'h0) return ST_COMBINED;
      // close the gap left by the cancelled term
      for (int j = i; j + 1 < poly_len[sel]; j++) begin
        poly_pw[sel][j] = poly_pw[sel][j + 1];
        poly_cf[sel][j] = poly_cf[sel][j + 1];
      end
      poly_len[sel]--;
      return ST_CANCELLED;
    end
    if (poly_len[sel] >= TERMS) return ST_FULL;
    for (int j = poly_len[sel]; j > i; j--) begin
      poly_pw[sel][j] = poly_pw[sel][j - 1];
      poly_cf[sel][j] = poly_cf[sel][j - 1];
    end
    poly_pw[sel][i] = pw;
    poly_cf[sel][i] = cf;
    poly_len[sel]++;
    return ST_NEW;
  endfunction

  // Walk A and B in descending power and queue every nonzero sum term.
  function automatic void merge_into_sum();
    int                 ia, ib;
    logic [31:0]        c;
    logic signed [15:0] p;
    result_t            terms[$];
    ia = 0;
    ib = 0;
    while (ia < poly_len[0] || ib < poly_len[1]) begin
      if (ib >= poly_len[1] || (ia < poly_len[0] && poly_pw[0][ia] > poly_pw[1][ib])) begin
        c = poly_cf[0][ia];
        p = poly_pw[0][ia];
        ia++;
      end else if (ia >= poly_len[0] || poly_pw[1][ib] > poly_pw[0][ia]) begin
        c = poly_cf[1][ib];
        p = poly_pw[1][ib];
        ib++;
      end else begin
        c = poly_cf[0][ia] + poly_cf[1][ib];
        p = poly_pw[0][ia];
        ia++;
        ib++;
      end
      if (c != 32'h0) terms.push_back('{ST_SUM, c, p, 1'b0});
    end
    if (terms.size() == 0) begin
      owed_results.push_back('{ST_SUM_EMPTY, 32'sh0, 16'sh0, 1'b1});
      status_hits[ST_SUM_EMPTY]++;
    end else begin
      terms[terms.size() - 1].last = 1'b1;
      foreach (terms[k]) owed_results.push_back(terms[k]);
      status_hits[ST_SUM] += terms.size();
    end
  endfunction

  // Update the shadow tables for one accepted command and queue what it must produce.
  function automatic void apply_command(command_t cmd);
    logic [2:0] st;
    case (cmd.func)
      FUNC_INS_A, FUNC_INS_B: begin
        st = insert_term(cmd.func == FUNC_INS_A ? 0 : 1, cmd.coeff, cmd.power);
        owed_results.push_back('{st, 32'sh0, 16'sh0, 1'b1});
        status_hits[st]++;
      end
      FUNC_CLEAR: begin
        poly_len[0] = 0;
        poly_len[1] = 0;
        owed_results.push_back('{ST_CLEARED, 32'sh0, 16'sh0, 1'b1});
        status_hits[ST_CLEARED]++;
      end
      default: merge_into_sum();
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Random stimulus. Episodes are short runs of inserts followed by a sum, so the tables
  // build up and the sums carry real content; a few noise commands are mixed in.
  // ---------------------------------------------------------------------------------------
  function automatic void add_cmd(logic [1:0] f, logic [31:0] c, logic [15:0] p);
    stimulus.push_back('{f, c, p, 1'b0, ST_NEW});
  endfunction

  // Favor zero, small values that merge and cancel, and the wrap-around extremes.
  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1, 2:    return 32'(int'($urandom_range(0, 6)) - 3);
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fffffff;
          1:       return 32'h80000000;
          2:       return 32'h80000001;
          default: return 32'hffffffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Fill both tables to the limit with interleaved powers, then push past it.
  function automatic void add_fill_episode();
    int base;
    bit ascending;
    base = int'($urandom_range(0, 65535 - 80)) - 32768;
    ascending = $urandom_range(0, 1) != 0;
    add_cmd(FUNC_CLEAR, $urandom, 16'($urandom));
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < TERMS; i++)
        add_cmd(t == 0 ? FUNC_INS_A : FUNC_INS_B, $urandom | 32'h1,
                16'(base + 2 * (ascending ? i : TERMS - 1 - i) + t));
    add_cmd(FUNC_INS_A, $urandom | 32'h1, 16'(base + 2 * TERMS + 2));   // no room left
    add_cmd(FUNC_INS_B, $urandom | 32'h1, 16'(base - 1));
    add_cmd(FUNC_INS_B, pick_coeff(), 16'(base + 1));                  // merge still allowed
    add_cmd(FUNC_SUM, $urandom, 16'($urandom));
    add_cmd(FUNC_CLEAR, $urandom, 16'($urandom));
  endfunction

  function automatic void add_random_episode();
    int base, cnt;
    bit narrow;
    base = int'($urandom_range(0, 65535));
    narrow = $urandom_range(0, 2) != 0;
    cnt = $urandom_range(1, 12);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 11) == 0)
        add_cmd(2'($urandom), $urandom, 16'($urandom));
      else
        add_cmd($urandom_range(0, 1) ? FUNC_INS_B : FUNC_INS_A, pick_coeff(),
                narrow ? 16'(base + int'($urandom_range(0, 7))) : 16'($urandom));
    end
    add_cmd(FUNC_SUM, $urandom, 16'($urandom));
    if ($urandom_range(0, 3) == 0) add_cmd(FUNC_CLEAR, $urandom, 16'($urandom));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender: present commands in order, hold a stalled transaction, idle in random bursts.
  // The shadow model advances at the edge where the block takes the command.
  // ---------------------------------------------------------------------------------------
  int tx_gap_left = 0;
  int tx_cycle = 0;
  bit tx_gap_mode = 1'b1;

  always @(posedge clk) begin
    bit took;
    bit quiet;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        apply_command(stimulus[send_idx]);
        // typed rows replace the single predicted result with the hand-written one
        if (stimulus[send_idx].has_exp) begin
          void'(owed_results.pop_back());
          owed_results.push_back('{stimulus[send_idx].status, 32'sh0, 16'sh0, 1'b1});
        end
        send_idx++;
      end
      tx_cycle++;
      if (tx_cycle % 64 == 0) tx_gap_mode = $urandom_range(0, 2) != 0;
      quiet = send_idx >= stimulus.size() - QUIET_ITEMS;
      if (in_valid && !took) begin
        // hold the stalled transaction as it is
      end else if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (send_idx < stimulus.size() && !quiet && tx_gap_mode &&
                   $urandom_range(0, 4) == 0) begin
        tx_gap_left = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (send_idx < stimulus.size()) begin
        in_func       <= stimulus[send_idx].func;
        in_term_coeff <= stimulus[send_idx].coeff;
        in_term_power <= stimulus[send_idx].power;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: random stall bursts, one long freeze so the block backs up into its input.
  // ---------------------------------------------------------------------------------------
  int rx_seen = 0;
  int rx_cycle = 0;
  int rx_stall_left = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;
  bit rx_stall_mode = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) rx_seen++;
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_stall_mode = $urandom_range(0, 2) != 0;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (!rx_hold_done && rx_seen >= HOLD_AT) begin
        rx_hold_done = 1'b1;
        rx_hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_seen >= stimulus.size() - QUIET_ITEMS) begin
        out_stall <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else if (rx_stall_mode && $urandom_range(0, 5) == 0) begin
        rx_stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result check: every accepted result against the oldest owed one, field by field.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(string field_name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, field_name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, actual status %0d",
                   $time, out_status);
      end else begin
        want = owed_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("coeff", want.coeff, out_coeff);
        check_field("power", 32'(want.power), 32'(out_power));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t ns: timeout after %0d cycles, %0d results still owed",
             $time, cycle_cnt, owed_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence: build the stimulus, reset once, wait for everything to drain, report.
  // ---------------------------------------------------------------------------------------
  initial begin
    poly_len[0] = 0;
    poly_len[1] = 0;
    foreach (status_hits[s]) status_hits[s] = 0;
    foreach (directed_rows[r]) stimulus.push_back(directed_rows[r]);
    add_fill_episode();   // guarantees full tables and a maximal sum early on
    while (stimulus.size() < $size(directed_rows) + RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) add_fill_episode();
      else add_random_episode();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge, away from the updates made at the rising edge
    do @(negedge clk); while (send_idx < stimulus.size() || owed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (owed_results.size() != 0) begin
      errors += owed_results.size();
      $display("%0t ns: results never delivered, expected %0d more, actual 0",
               $time, owed_results.size());
    end
    $display("Ran %0d commands and checked %0d results over %0d cycles.",
             stimulus.size(), results_seen, cycle_cnt);
    $display("Outcomes new/comb/cancel/zero/full/term/empty/clear: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_hits[ST_NEW], status_hits[ST_COMBINED], status_hits[ST_CANCELLED],
             status_hits[ST_ZERO], status_hits[ST_FULL], status_hits[ST_SUM],
             status_hits[ST_SUM_EMPTY], status_hits[ST_CLEARED]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
